FILE: src/bph_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the byte pair histogram plotter.
// No dependencies; used by the channel interfaces and the top level.
package bph_pkg;

  localparam int unsigned TableSide  = 256;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned AddrW      = 2 * ByteW;
  localparam int unsigned AreaW      = 13;
  localparam int unsigned PosW       = 12;
  localparam int unsigned CellW      = 5;
  localparam int unsigned NumColors  = 16;
  localparam int unsigned ColorConstW = $clog2(NumColors + 1);

  localparam logic [ByteW-1:0] CountMax = 8'd255;
  localparam logic [PosW-1:0]  PosMax   = 12'd4095;
  localparam logic [CellW-1:0] CellMax  = 5'd31;

  localparam logic [AreaW-1:0] AreaReset = 13'd256;
  localparam logic [AreaW-1:0] AreaSide  = 13'd256;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdStart = 2'd1,
    CmdCont  = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegAreaWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAreaHeight = 2'd1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ByteW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]  x_pos;
    logic [PosW-1:0]  y_pos;
    logic [ByteW-1:0] color_level;
    logic [ByteW-1:0] pair_count;
    logic             draw_rect;
    logic [CellW-1:0] rect_w;
    logic [CellW-1:0] rect_h;
  } out_item_t;

endpackage

FILE: src/bph_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying input items (command and data byte).
// Depends on bph_pkg.
interface bph_in_if;
  logic               valid;
  logic               ready;
  bph_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/bph_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying plot point items.
// Depends on bph_pkg.
interface bph_out_if;
  logic               valid;
  logic               ready;
  bph_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/byte_pair_histogram_plot.sv
`timescale 1ns / 1ps
// Byte pair histogram plotter: 64K x 8 pair count memory with read-modify-write.
// Depends on bph_pkg, bph_in_if and bph_out_if.
//
//  channel   dir  content                                   handshake
//  in_i      in   cmd, data_byte                            valid/ready
//  out_o     out  x_pos, y_pos, color_level, pair_count,    valid/ready
//                 draw_rect, rect_w, rect_h
//  cfg_*     in   area_width / area_height write            we, no wait
//
// One item per cycle unless the output stalls or a clearing pass runs. A
// continuation item reads the count memory on acceptance, and the write stage
// writes back the incremented count; a back-to-back hit on the same pair is
// forwarded from the write stage. A result moves from the write stage to the output register.
// After reset and after each clear item, a clearing pass zeroes all 65536 entries
// of the count memory, one entry a cycle; no item is accepted meanwhile.
// A stalled output register holds the write stage, which then blocks input.
module byte_pair_histogram_plot (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bph_in_if.sink                         in_i,
  bph_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [bph_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bph_pkg::AreaW-1:0]      cfg_data_i
);

  localparam int unsigned AW = bph_pkg::AddrW;
  localparam int unsigned BW = bph_pkg::ByteW;
  localparam int unsigned XW = bph_pkg::AreaW + BW;

  // Count memory
  logic [BW-1:0] cnt_mem [2**AW];
  logic [BW-1:0] rd_q;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [BW-1:0] mem_wd;

  // Control state
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;
  logic          have_prev_q;
  logic [BW-1:0] prev_q;
  logic          s1_valid_q;
  logic          out_valid_q;
  logic [bph_pkg::AreaW-1:0] area_w_q;
  logic [bph_pkg::AreaW-1:0] area_h_q;

  // Write stage payload
  logic [BW-1:0] s1_prev_q;
  logic [BW-1:0] s1_cur_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_fwd_q;
  logic [BW-1:0] s1_fwd_cnt_q;
  bph_pkg::out_item_t out_data_q;
  bph_pkg::out_item_t point;

  logic          in_fire;
  logic          is_clear;
  logic          is_start;
  logic          is_cont;
  logic          s1_adv;
  logic [BW-1:0] old_cnt;
  logic [BW-1:0] new_cnt;
  logic [XW-1:0] x_prod;
  logic [XW-1:0] y_prod;
  logic [bph_pkg::AreaW-1:0] x_scaled;
  logic [bph_pkg::AreaW-1:0] y_scaled;
  logic [bph_pkg::ColorConstW+BW-1:0] color_prod;
  logic          draw_rect;
  logic [bph_pkg::CellW:0] cell_w;
  logic [bph_pkg::CellW:0] cell_h;
  logic [bph_pkg::CellW-1:0] div_w;
  logic [bph_pkg::CellW-1:0] div_h;

  // Handshake and command decode
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_clear   = in_i.data.cmd == bph_pkg::CmdClear;
  assign is_cont    = (in_i.data.cmd == bph_pkg::CmdCont) && have_prev_q;
  assign is_start   = (in_i.data.cmd == bph_pkg::CmdStart) ||
                      ((in_i.data.cmd == bph_pkg::CmdCont) && !have_prev_q);

  assign mem_re = in_fire && is_cont;
  assign mem_ra = {prev_q, in_i.data.data_byte};

  // Saturating increment, forwarded count wins over stale read data
  assign old_cnt = s1_fwd_q ? s1_fwd_cnt_q : rd_q;
  assign new_cnt = (old_cnt == bph_pkg::CountMax) ? old_cnt : old_cnt + 1'b1;

  // Memory write: clearing pass or write-back of the write stage
  always_comb begin
    mem_we = 1'b0;
    mem_wa = s1_addr_q;
    mem_wd = new_cnt;
    if (clearing_q) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = '0;
    end else if (s1_adv) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= cnt_mem[mem_ra];
    end
  end

  // Point geometry
  assign x_prod   = XW'(s1_prev_q) * XW'(area_w_q);
  assign y_prod   = XW'(s1_cur_q) * XW'(area_h_q);
  assign x_scaled = x_prod[XW-1:BW];
  assign y_scaled = y_prod[XW-1:BW];
  assign draw_rect = (area_w_q > bph_pkg::AreaSide) || (area_h_q > bph_pkg::AreaSide);
  assign div_w    = area_w_q[bph_pkg::AreaW-1:BW];
  assign div_h    = area_h_q[bph_pkg::AreaW-1:BW];
  assign cell_w   = (div_w == '0) ? (bph_pkg::CellW+1)'(2) : {1'b0, div_w} + 1'b1;
  assign cell_h   = (div_h == '0) ? (bph_pkg::CellW+1)'(2) : {1'b0, div_h} + 1'b1;
  assign color_prod = (bph_pkg::ColorConstW+BW)'(bph_pkg::NumColors) *
                      (bph_pkg::ColorConstW+BW)'(new_cnt);

  always_comb begin
    point.x_pos = (x_scaled > bph_pkg::AreaW'(bph_pkg::PosMax)) ? bph_pkg::PosMax
                                                                : x_scaled[bph_pkg::PosW-1:0];
    point.y_pos = (y_scaled > bph_pkg::AreaW'(bph_pkg::PosMax)) ? bph_pkg::PosMax
                                                                : y_scaled[bph_pkg::PosW-1:0];
    point.color_level = BW'(color_prod[bph_pkg::ColorConstW+BW-1:BW]);
    point.pair_count  = new_cnt;
    point.draw_rect   = draw_rect;
    point.rect_w = '0;
    point.rect_h = '0;
    if (draw_rect) begin
      point.rect_w = cell_w[bph_pkg::CellW] ? bph_pkg::CellMax : cell_w[bph_pkg::CellW-1:0];
      point.rect_h = cell_h[bph_pkg::CellW] ? bph_pkg::CellMax : cell_h[bph_pkg::CellW-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      area_w_q    <= bph_pkg::AreaReset;
      area_h_q    <= bph_pkg::AreaReset;
    end else begin
      // advance clearing pass
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      // take item
      if (in_fire) begin
        if (is_clear) begin
          clearing_q <= 1'b1;
          clr_addr_q <= '0;
        end
        if (is_start || is_cont) begin
          prev_q      <= in_i.data.data_byte;
          have_prev_q <= 1'b1;
        end
      end
      // write stage occupancy
      if (!s1_valid_q || s1_adv) begin
        s1_valid_q <= in_fire && is_cont;
      end
      // output register
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bph_pkg::RegAreaWidth:  area_w_q <= cfg_data_i;
          bph_pkg::RegAreaHeight: area_h_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      s1_prev_q    <= prev_q;
      s1_cur_q     <= in_i.data.data_byte;
      s1_addr_q    <= mem_ra;
      s1_fwd_q     <= s1_adv && (s1_addr_q == mem_ra);
      s1_fwd_cnt_q <= new_cnt;
    end
    if (s1_adv) begin
      out_data_q <= point;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
